// ===== src/connection_tracking_table_assert.svh =====
// Assertion macros, clocked on clk with reset rst_n.
`ifndef CONNECTION_TRACKING_TABLE_ASSERT_SVH
`define CONNECTION_TRACKING_TABLE_ASSERT_SVH

// cond in the same cycle implies prop
`define CTT_ASSERT_IMP(name, cond, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("ctt assertion failed");

// cond implies prop in the next cycle
`define CTT_ASSERT_NEXT(name, cond, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("ctt assertion failed");

`endif

// ===== src/ctt_pkg.sv =====
`default_nettype none
package ctt_pkg;

    localparam int NPROBE = 8;

    localparam logic [1:0] FUNC_INSERT = 2'd0;
    localparam logic [1:0] FUNC_LOOKUP = 2'd1;
    localparam logic [1:0] FUNC_DELETE = 2'd2;

    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_FULL = 2'd1;
    localparam logic [1:0] STATUS_MISS = 2'd2;

    localparam logic [31:0] TIMEOUT_RESET = 32'd1000000;

    localparam logic [2:0] CMD_NONE   = 3'd0;
    localparam logic [2:0] CMD_INSERT = 3'd1;
    localparam logic [2:0] CMD_TOUCH  = 3'd2;
    localparam logic [2:0] CMD_FREE   = 3'd3;
    localparam logic [2:0] CMD_EXPIRE = 3'd4;

    typedef struct packed {
        logic [7:0]  proto;
        logic [63:0] addrs;
        logic [31:0] ports;
    } key_t;

    typedef struct packed {
        logic [2:0]  op;
        key_t        key;
        logic [7:0]  handler;
        logic [7:0]  requestor;
        logic        reuse;
        logic [47:0] now;
        logic [31:0] timeout;
    } cmd_t;

    typedef struct packed {
        logic        hit;
        logic [15:0] age;
        logic [7:0]  handler;
        logic [7:0]  requestor;
        logic        reuse;
    } probe_best_t;

endpackage
`default_nettype wire

// ===== src/ctt_cell.sv =====
`default_nettype none
module ctt_cell
    import ctt_pkg::*;
#(
    parameter int SW  = 6,
    parameter int IW  = 6,
    parameter int IDX = 0
) (
    input  wire                                clk,
    input  wire                                rst_n,
    input  cmd_t                               cmd,
    input  wire  [IW-1:0]                      cmd_slot,
    input  key_t [NPROBE-1:0]                  keys,
    input  wire  [15:0]                        ins_cnt,
    input  probe_best_t [NPROBE-1:0]           best_in,
    input  wire  [NPROBE-1:0][SW-1:0]          bslot_in,
    input  wire                                free_found_in,
    input  wire  [SW-1:0]                      free_slot_in,
    output probe_best_t [NPROBE-1:0]           best_out,
    output logic [NPROBE-1:0][SW-1:0]          bslot_out,
    output logic                               free_found_out,
    output logic [SW-1:0]                      free_slot_out
);

    logic        valid_reg, valid_next;
    key_t        key_reg;
    logic [7:0]  handler_reg;
    logic [7:0]  requestor_reg;
    logic        reuse_reg;
    logic [47:0] last_reg;
    logic [15:0] seq_reg;

    logic        sel;
    logic        expired;
    logic [47:0] idle;
    logic [15:0] age;
    probe_best_t [NPROBE-1:0]  best_next;
    logic [NPROBE-1:0][SW-1:0] bslot_next;
    logic                      free_found_next;
    logic [SW-1:0]             free_slot_next;

    assign sel     = (cmd_slot == IW'(IDX));
    assign idle    = cmd.now - last_reg;
    assign expired = (cmd.now >= last_reg) && (idle > {16'd0, cmd.timeout});
    assign age     = ins_cnt - seq_reg;

    always_comb
    begin
        valid_next = valid_reg;
        case (cmd.op)
            CMD_INSERT: if (sel) valid_next = 1'b1;
            CMD_FREE:   if (sel) valid_next = 1'b0;
            CMD_EXPIRE: if (valid_reg && expired) valid_next = 1'b0;
            default:    valid_next = valid_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == CMD_INSERT && sel)
        begin
            key_reg       <= cmd.key;
            handler_reg   <= cmd.handler;
            requestor_reg <= cmd.requestor;
            reuse_reg     <= cmd.reuse;
            last_reg      <= cmd.now;
            seq_reg       <= ins_cnt;
        end
        else if (cmd.op == CMD_TOUCH && sel)
        begin
            last_reg <= cmd.now;
        end
    end

    // running best per probe; strict compare keeps the lower slot on a tie
    always_comb
    begin
        best_next       = best_in;
        bslot_next      = bslot_in;
        free_found_next = free_found_in;
        free_slot_next  = free_slot_in;
        if (!free_found_in && !valid_reg)
        begin
            free_found_next = 1'b1;
            free_slot_next  = SW'(IDX);
        end
        for (int k = 0; k < NPROBE; k++)
        begin
            if (valid_reg && key_reg == keys[k] && (!best_in[k].hit || age < best_in[k].age))
            begin
                best_next[k].hit       = 1'b1;
                best_next[k].age       = age;
                best_next[k].handler   = handler_reg;
                best_next[k].requestor = requestor_reg;
                best_next[k].reuse     = reuse_reg;
                bslot_next[k]          = SW'(IDX);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_out       <= '0;
            bslot_out      <= '0;
            free_found_out <= 1'b0;
            free_slot_out  <= '0;
        end
        else
        begin
            best_out       <= best_next;
            bslot_out      <= bslot_next;
            free_found_out <= free_found_next;
            free_slot_out  <= free_slot_next;
        end
    end

endmodule
`default_nettype wire

// ===== src/connection_tracking_table.sv =====
// Flow: insert walks the cell chain; lookup runs an expire pass, then walks the chain;
// delete and unused codes go straight to the decide step; the result is registered.
// Throughput: one item at a time; next input taken once the result is registered.
// Reset: asynchronous, active low; all entries free, insert count zero, timeout 1000000 us.
`default_nettype none
module connection_tracking_table
    import ctt_pkg::*;
#(
    parameter int ENTRIES      = 64,
    parameter int UNKNOWN_PORT = 0
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [31:0] cfg_data,
    input  wire         in_valid,
    output logic        in_ready,
    input  wire  [1:0]  func,
    input  wire  [7:0]  ip_protocol,
    input  wire  [31:0] addr_a,
    input  wire  [15:0] port_a,
    input  wire  [31:0] addr_b,
    input  wire  [15:0] port_b,
    input  wire         reuse,
    input  wire  [7:0]  handler_id,
    input  wire  [7:0]  requestor_id,
    input  wire  [47:0] now_us,
    input  wire  [5:0]  slot,
    output logic        out_valid,
    input  wire         out_ready,
    output logic [1:0]  status,
    output logic [5:0]  entry_slot,
    output logic [7:0]  found_handler,
    output logic [7:0]  found_requestor,
    output logic [2:0]  matched_probe
);

    localparam int SW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int IW = (SW > 6) ? SW : 6;
    localparam logic [15:0] UPORT = 16'(UNKNOWN_PORT);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EXPIRE = 3'd1;
    localparam logic [2:0] S_WALK   = 3'd2;
    localparam logic [2:0] S_DECIDE = 3'd3;

    logic [2:0]  state_reg, state_next;
    logic [SW-1:0] walk_cnt_reg, walk_cnt_next;
    logic [31:0] timeout_reg;
    logic [15:0] ins_cnt_reg, ins_cnt_next;

    logic [1:0]  func_reg;
    logic [7:0]  proto_reg;
    logic [31:0] a_reg, b_reg;
    logic [15:0] pa_reg, pb_reg;
    logic        reuse_reg;
    logic [7:0]  handler_reg, requestor_reg;
    logic [47:0] now_reg;
    logic [5:0]  slot_reg;

    logic        out_valid_reg;
    logic [1:0]  status_reg, status_next;
    logic [5:0]  entry_slot_reg, entry_slot_next;
    logic [7:0]  handler_out_reg, handler_out_next;
    logic [7:0]  requestor_out_reg, requestor_out_next;
    logic [2:0]  probe_out_reg, probe_out_next;

    cmd_t              cmd;
    logic [IW-1:0]     cmd_slot;
    key_t [NPROBE-1:0] keys;
    logic              go;
    logic              any_hit;
    logic [2:0]        hit_k;
    logic [IW-1:0]     wide_slot;

    probe_best_t [NPROBE-1:0]  best_chain  [ENTRIES+1];
    logic [NPROBE-1:0][SW-1:0] bslot_chain [ENTRIES+1];
    logic                      ff_chain    [ENTRIES+1];
    logic [SW-1:0]             fs_chain    [ENTRIES+1];

    assign cfg_ready       = 1'b1;
    assign in_ready        = (state_reg == S_IDLE);
    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign entry_slot      = entry_slot_reg;
    assign found_handler   = handler_out_reg;
    assign found_requestor = requestor_out_reg;
    assign matched_probe   = probe_out_reg;

    assign keys[0] = '{proto_reg, {a_reg, b_reg}, {pa_reg, pb_reg}};
    assign keys[1] = '{proto_reg, {b_reg, a_reg}, {pb_reg, pa_reg}};
    assign keys[2] = '{proto_reg, {a_reg, 32'd0}, {pa_reg, pb_reg}};
    assign keys[3] = '{proto_reg, {b_reg, 32'd0}, {pb_reg, pa_reg}};
    assign keys[4] = '{proto_reg, {a_reg, b_reg}, {pa_reg, UPORT}};
    assign keys[5] = '{proto_reg, {b_reg, a_reg}, {pb_reg, UPORT}};
    assign keys[6] = '{proto_reg, {a_reg, 32'd0}, {pa_reg, UPORT}};
    assign keys[7] = '{proto_reg, {b_reg, 32'd0}, {pb_reg, UPORT}};

    assign best_chain[0]  = '0;
    assign bslot_chain[0] = '0;
    assign ff_chain[0]    = 1'b0;
    assign fs_chain[0]    = '0;

    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        ctt_cell #(
            .SW  (SW),
            .IW  (IW),
            .IDX (i)
        ) u_cell (
            .clk            (clk),
            .rst_n          (rst_n),
            .cmd            (cmd),
            .cmd_slot       (cmd_slot),
            .keys           (keys),
            .ins_cnt        (ins_cnt_reg),
            .best_in        (best_chain[i]),
            .bslot_in       (bslot_chain[i]),
            .free_found_in  (ff_chain[i]),
            .free_slot_in   (fs_chain[i]),
            .best_out       (best_chain[i+1]),
            .bslot_out      (bslot_chain[i+1]),
            .free_found_out (ff_chain[i+1]),
            .free_slot_out  (fs_chain[i+1])
        );
    end

    assign go = !out_valid_reg || out_ready;

    always_comb
    begin
        any_hit = 1'b0;
        hit_k   = '0;
        for (int k = NPROBE - 1; k >= 0; k--)
        begin
            if (best_chain[ENTRIES][k].hit)
            begin
                any_hit = 1'b1;
                hit_k   = 3'(k);
            end
        end
    end

    always_comb
    begin
        state_next         = state_reg;
        walk_cnt_next      = walk_cnt_reg;
        ins_cnt_next       = ins_cnt_reg;
        status_next        = status_reg;
        entry_slot_next    = entry_slot_reg;
        handler_out_next   = handler_out_reg;
        requestor_out_next = requestor_out_reg;
        probe_out_next     = probe_out_reg;
        wide_slot          = '0;
        cmd_slot           = '0;
        cmd.op             = CMD_NONE;
        cmd.key            = keys[0];
        cmd.handler        = handler_reg;
        cmd.requestor      = requestor_reg;
        cmd.reuse          = reuse_reg;
        cmd.now            = now_reg;
        cmd.timeout        = timeout_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    walk_cnt_next = '0;
                    if (func == FUNC_LOOKUP)
                        state_next = S_EXPIRE;
                    else if (func == FUNC_INSERT)
                        state_next = S_WALK;
                    else
                        state_next = S_DECIDE;
                end
            end
            S_EXPIRE:
            begin
                cmd.op     = CMD_EXPIRE;
                state_next = S_WALK;
            end
            S_WALK:
            begin
                walk_cnt_next = walk_cnt_reg + 1'b1;
                if (walk_cnt_reg == SW'(ENTRIES - 1))
                    state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (go)
                begin
                    state_next         = S_IDLE;
                    status_next        = STATUS_OK;
                    entry_slot_next    = '0;
                    handler_out_next   = '0;
                    requestor_out_next = '0;
                    probe_out_next     = '0;
                    case (func_reg)
                        FUNC_INSERT:
                        begin
                            if (ff_chain[ENTRIES])
                            begin
                                wide_slot       = IW'(fs_chain[ENTRIES]);
                                cmd.op          = CMD_INSERT;
                                cmd_slot        = wide_slot;
                                entry_slot_next = wide_slot[5:0];
                                ins_cnt_next    = ins_cnt_reg + 16'd1;
                            end
                            else
                            begin
                                status_next = STATUS_FULL;
                            end
                        end
                        FUNC_LOOKUP:
                        begin
                            if (any_hit)
                            begin
                                wide_slot          = IW'(bslot_chain[ENTRIES][hit_k]);
                                cmd.op             = best_chain[ENTRIES][hit_k].reuse ?
                                                     CMD_TOUCH : CMD_FREE;
                                cmd_slot           = wide_slot;
                                entry_slot_next    = wide_slot[5:0];
                                handler_out_next   = best_chain[ENTRIES][hit_k].handler;
                                requestor_out_next = best_chain[ENTRIES][hit_k].requestor;
                                probe_out_next     = hit_k;
                            end
                            else
                            begin
                                status_next = STATUS_MISS;
                            end
                        end
                        FUNC_DELETE:
                        begin
                            cmd.op          = CMD_FREE;
                            cmd_slot        = IW'(slot_reg);
                            entry_slot_next = slot_reg;
                        end
                        default:
                        begin
                            status_next = STATUS_OK;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            walk_cnt_reg  <= '0;
            ins_cnt_reg   <= '0;
            timeout_reg   <= TIMEOUT_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            walk_cnt_reg <= walk_cnt_next;
            ins_cnt_reg  <= ins_cnt_next;
            if (cfg_valid)
                timeout_reg <= cfg_data;
            if (state_reg == S_DECIDE && go)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            func_reg      <= func;
            proto_reg     <= ip_protocol;
            a_reg         <= addr_a;
            pa_reg        <= port_a;
            b_reg         <= addr_b;
            pb_reg        <= port_b;
            reuse_reg     <= reuse;
            handler_reg   <= handler_id;
            requestor_reg <= requestor_id;
            now_reg       <= now_us;
            slot_reg      <= slot;
        end
        status_reg        <= status_next;
        entry_slot_reg    <= entry_slot_next;
        handler_out_reg   <= handler_out_next;
        requestor_out_reg <= requestor_out_next;
        probe_out_reg     <= probe_out_next;
    end

`include "connection_tracking_table_assert.svh"

    `CTT_ASSERT_NEXT(a_accept_busy, in_valid && in_ready, state_reg != S_IDLE)
    `CTT_ASSERT_IMP(a_miss_zero, out_valid && status == STATUS_MISS,
                    found_handler == 8'd0 && matched_probe == 3'd0)
    `CTT_ASSERT_NEXT(a_cnt_hold, cmd.op != CMD_INSERT, $stable(ins_cnt_reg))
    `CTT_ASSERT_IMP(a_cmd_decide, cmd.op == CMD_INSERT || cmd.op == CMD_TOUCH,
                    state_reg == S_DECIDE && go)

endmodule
`default_nettype wire
